// File: rtl/core/learned_count_min_sketch_unit_assert.svh
// assertion macros for the learned count-min sketch unit
`ifndef LEARNED_COUNT_MIN_SKETCH_UNIT_ASSERT_SVH
`define LEARNED_COUNT_MIN_SKETCH_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LCMS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LCMS_ASSERT(label, clk, rst_n, prop, msg)
`define LCMS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/lcms_pkg.sv
// shared types and constants for the learned count-min sketch
package lcms_pkg;
    localparam int KEY_W   = 64;
    localparam int CHG_W   = 32;
    localparam int PRED_W  = 16;
    localparam int EST_W   = 32;
    localparam int STAT_W  = 2;
    localparam int SEED_W  = 64;
    localparam int NSEEDS  = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic REQ_UPDATE   = 1'b0;
    localparam logic REQ_ESTIMATE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED3  = 3'd4;

    localparam logic [PRED_W-1:0] THRESH_RST = 16'd32768;
endpackage

// File: rtl/core/lcms_if.sv
// valid/ready stream interface carrying request or result payload
interface lcms_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [lcms_pkg::KEY_W-1:0]  item_key;
    logic signed [lcms_pkg::CHG_W-1:0] count_change;
    logic [lcms_pkg::PRED_W-1:0] predicted_score;
    modport source (output valid, req_type, item_key, count_change, predicted_score,
                    input ready);
    modport sink (input valid, req_type, item_key, count_change, predicted_score,
                  output ready);
endinterface

interface lcms_res_if;
    logic                        valid;
    logic                        ready;
    logic signed [lcms_pkg::EST_W-1:0] freq_estimate;
    logic [lcms_pkg::STAT_W-1:0] status_code;
    modport source (output valid, freq_estimate, status_code, input ready);
    modport sink (input valid, freq_estimate, status_code, output ready);
endinterface

// File: rtl/core/lcms_front.sv
// front end: accepts requests, classifies heavy or sketch, hashes columns
module lcms_front #(
    parameter int ROWS     = 4,
    parameter int COL_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_req_type,
    input  logic [lcms_pkg::KEY_W-1:0]  i_item_key,
    input  logic [lcms_pkg::CHG_W-1:0]  i_count_change,
    input  logic [lcms_pkg::PRED_W-1:0] i_predicted_score,
    input  logic [lcms_pkg::PRED_W-1:0] i_thresh,
    input  logic [lcms_pkg::NSEEDS-1:0][lcms_pkg::SEED_W-1:0] i_seeds,
    output logic                        o_push,
    input  logic                        i_full,
    output logic [ROWS*COL_BITS+lcms_pkg::KEY_W+lcms_pkg::CHG_W+1:0] o_data
);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    typedef enum logic [1:0] {S_IDLE, S_HASH, S_PUSH} t_state;

    t_state r_state;
    logic [lcms_pkg::KEY_W-1:0] r_key;
    logic [lcms_pkg::CHG_W-1:0] r_chg;
    logic r_req, r_heavy;
    logic [RW-1:0] r_row;
    logic [ROWS-1:0][COL_BITS-1:0] r_cols;

    // multiply-shift hash as three 32x32 partial products, one row a cycle
    logic [lcms_pkg::SEED_W-1:0] w_seed;
    logic [63:0] w_ll, w_lh, w_hl, w_prod;
    assign w_seed = i_seeds[r_row];
    assign w_ll = r_key[31:0] * w_seed[31:0];
    assign w_lh = r_key[31:0] * w_seed[63:32];
    assign w_hl = r_key[63:32] * w_seed[31:0];
    assign w_prod = w_ll + {w_lh[31:0], 32'd0} + {w_hl[31:0], 32'd0};

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_data  = {r_req, r_heavy, r_key, r_chg, r_cols};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_key   <= i_item_key;
                        r_chg   <= i_count_change;
                        r_req   <= i_req_type;
                        r_heavy <= i_predicted_score > i_thresh;
                        r_row   <= '0;
                        r_state <= (i_predicted_score > i_thresh) ? S_PUSH : S_HASH;
                    end
                end
                S_HASH: begin
                    r_cols[r_row] <= w_prod[63 -: COL_BITS];
                    if (r_row == RW'(ROWS-1)) r_state <= S_PUSH;
                    else r_row <= r_row + 1'b1;
                end
                S_PUSH: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/lcms_queue.sv
// short fifo between front and back ends
module lcms_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [1:0][W-1:0] r_mem;
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`include "learned_count_min_sketch_unit_assert.svh"
    `LCMS_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "queue overflow")
    `LCMS_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "queue underflow")
    `LCMS_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "queue count out of range")
endmodule

// File: rtl/core/lcms_back.sv
// back end: counter memory read-modify-write, heavy table search, result register
module lcms_back #(
    parameter int ROWS          = 4,
    parameter int COL_BITS      = 10,
    parameter int HEAVY_ENTRIES = 64,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  logic [ROWS*COL_BITS+lcms_pkg::KEY_W+lcms_pkg::CHG_W+1:0] i_data,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic [lcms_pkg::EST_W-1:0]  o_est,
    output logic [lcms_pkg::STAT_W-1:0] o_stat,
    output logic o_clearing
);
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW   = RW + COL_BITS;
    localparam int DEPTH = ROWS << COL_BITS;
    localparam int HW   = (HEAVY_ENTRIES > 1) ? $clog2(HEAVY_ENTRIES) : 1;
    localparam int FW   = $clog2(HEAVY_ENTRIES + 1);
    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_WB, S_HSRCH, S_HACT, S_OUT} t_state;

    t_state r_state;
    logic [COUNT_WIDTH-1:0] r_cnt_mem [DEPTH];
    logic [lcms_pkg::KEY_W-1:0] r_hkey [HEAVY_ENTRIES];
    logic [COUNT_WIDTH-1:0] r_hcnt [HEAVY_ENTRIES];
    logic [FW-1:0] r_fill;
    logic [AW:0] r_clr;
    logic [RW-1:0] r_row;
    logic [HW:0] r_hi;
    logic r_found;
    logic [HW-1:0] r_slot;
    logic [COUNT_WIDTH-1:0] r_rd, r_min, r_hrd;
    logic [lcms_pkg::KEY_W-1:0] r_hk;
    logic r_first;
    logic [lcms_pkg::EST_W-1:0] r_est;
    logic [lcms_pkg::STAT_W-1:0] r_stat;

    // queue word fields
    logic w_req, w_heavy;
    logic [lcms_pkg::KEY_W-1:0] w_key;
    logic [lcms_pkg::CHG_W-1:0] w_chg;
    logic [ROWS-1:0][COL_BITS-1:0] w_cols;
    assign {w_req, w_heavy, w_key, w_chg, w_cols} = i_data;

    logic [COUNT_WIDTH-1:0] w_chgx, w_sum, w_val;
    logic [63:0] w_sx;
    logic [AW-1:0] w_addr;
    assign w_chgx = COUNT_WIDTH'({{(64-lcms_pkg::CHG_W){w_chg[lcms_pkg::CHG_W-1]}}, w_chg});
    assign w_addr = {r_row, w_cols[r_row]};
    assign w_sum  = r_rd + w_chgx;
    assign w_val  = r_state == S_HACT ? r_hrd : r_min;
    assign w_sx   = 64'(signed'(w_val));

    assign o_pop = (r_state == S_OUT) && i_ready;
    assign o_valid = (r_state == S_OUT);
    assign o_est = r_est;
    assign o_stat = r_stat;
    assign o_clearing = (r_state == S_CLR);

    // counter memory: one registered read port, one write port
    logic w_we;
    logic [AW-1:0] w_wa;
    logic [COUNT_WIDTH-1:0] w_wd;
    always_comb begin
        w_we = 1'b0; w_wa = w_addr; w_wd = w_sum;
        if (r_state == S_CLR) begin
            w_we = 1'b1; w_wa = r_clr[AW-1:0]; w_wd = '0;
        end else if (r_state == S_WB && w_req == lcms_pkg::REQ_UPDATE) begin
            w_we = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_we && (32'(w_wa) < DEPTH)) r_cnt_mem[w_wa] <= w_wd;
        r_rd <= r_cnt_mem[w_addr];
    end

    // heavy table: one entry read a cycle during the search
    always_ff @(posedge i_clk) begin
        r_hk  <= r_hkey[r_hi[HW-1:0]];
        r_hrd <= r_hcnt[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_fill <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_clr == (AW+1)'(DEPTH-1)) r_state <= S_IDLE;
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    r_row <= '0; r_hi <= '0; r_found <= 1'b0; r_first <= 1'b1;
                    r_slot <= '0;
                    if (!i_empty) r_state <= w_heavy ? S_HSRCH : S_RD;
                end
                S_RD: r_state <= S_WB;
                S_WB: begin
                    if (r_first || ($signed(r_rd) < $signed(r_min))) r_min <= r_rd;
                    r_first <= 1'b0;
                    if (r_row == RW'(ROWS-1)) begin
                        r_est <= '0; r_stat <= lcms_pkg::ST_OK;
                        if (w_req == lcms_pkg::REQ_ESTIMATE) begin
                            r_est <= lcms_pkg::EST_W'(64'(signed'(
                                (r_first || ($signed(r_rd) < $signed(r_min))) ? r_rd : r_min)));
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_row <= r_row + 1'b1; r_state <= S_RD;
                    end
                end
                S_HSRCH: begin
                    // r_hk holds the entry at r_hi-1, registered from the previous r_hi
                    if (r_hi != '0 && (HW+1)'(r_hi - 1'b1) < (HW+1)'(r_fill)
                        && r_hk == w_key && !r_found) begin
                        r_found <= 1'b1; r_slot <= HW'(r_hi - 1'b1);
                    end
                    // the search runs one step past the last slot so r_hrd follows a match on it
                    if (r_hi == (HW+1)'(HEAVY_ENTRIES + 1)) r_state <= S_HACT;
                    else r_hi <= r_hi + 1'b1;
                end
                S_HACT: begin
                    r_est <= '0; r_stat <= lcms_pkg::ST_OK;
                    if (w_req == lcms_pkg::REQ_UPDATE) begin
                        if (r_found) r_hcnt[r_slot] <= r_hrd + w_chgx;
                        else if (r_fill < FW'(HEAVY_ENTRIES)) begin
                            r_hkey[HW'(r_fill)] <= w_key;
                            r_hcnt[HW'(r_fill)] <= w_chgx;
                            r_fill <= r_fill + 1'b1;
                        end else r_stat <= lcms_pkg::ST_FULL;
                    end else begin
                        if (r_found) r_est <= lcms_pkg::EST_W'(w_sx);
                        else r_stat <= lcms_pkg::ST_NOTFOUND;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "learned_count_min_sketch_unit_assert.svh"
    `LCMS_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(HEAVY_ENTRIES), "fill beyond table")
    `LCMS_ASSERT(a_stat_code, i_clk, i_rst_n, !o_valid || o_stat != 2'd3, "bad status")
    `LCMS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_est)), "result dropped")
endmodule

// File: rtl/core/learned_count_min_sketch_unit.sv
// top level of the learned count-min sketch unit
// Usage:
//  Requests enter on req (valid/ready): req_type, item_key, count_change and
//  predicted_score. One result per request leaves on res: freq_estimate and
//  status_code. Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) must be
//  made only while the unit is idle; the unit does not enforce this. Index
//  0 is the threshold, 1..4 the row seeds. The front stage hashes one
//  sketch row per cycle with a split 64-bit multiply, a two-entry queue
//  decouples it from the back stage, which reads the counter memory row by
//  row (states S_RD, S_WB) and writes it back for updates, or scans the
//  heavy table one slot a cycle. The front can take a new request while the
//  back stage still works on an earlier one. After reset a clearing pass
//  zeroes all ROWS*2^COL_BITS counters, and no request is taken meanwhile.
//  A stalled receiver holds the result register; the queue then fills and
//  the front drops ready.
module learned_count_min_sketch_unit #(
    parameter int ROWS          = 4,
    parameter int COL_BITS      = 10,
    parameter int HEAVY_ENTRIES = 64,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lcms_req_if.sink   req,
    lcms_res_if.source res,
    input  logic                            i_cfg_we,
    input  logic [lcms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcms_pkg::SEED_W-1:0]     i_cfg_data
);
    localparam int QW = ROWS*COL_BITS + lcms_pkg::KEY_W + lcms_pkg::CHG_W + 2;

    logic [lcms_pkg::PRED_W-1:0] r_thresh;
    logic [lcms_pkg::NSEEDS-1:0][lcms_pkg::SEED_W-1:0] r_seeds;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= lcms_pkg::THRESH_RST;
            r_seeds[0] <= 64'd1; r_seeds[1] <= 64'd3;
            r_seeds[2] <= 64'd5; r_seeds[3] <= 64'd7;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lcms_pkg::CFG_THRESH)
                r_thresh <= i_cfg_data[lcms_pkg::PRED_W-1:0];
            else if (i_cfg_idx inside {[lcms_pkg::CFG_SEED0:lcms_pkg::CFG_SEED3]})
                r_seeds[2'(i_cfg_idx - lcms_pkg::CFG_SEED0)] <= i_cfg_data | 64'd1;
        end
    end

    logic w_push, w_full, w_pop, w_empty, w_clr, w_fready;
    logic [QW-1:0] w_qin, w_qout;

    assign req.ready = w_fready && !w_clr;

    lcms_front #(.ROWS(ROWS), .COL_BITS(COL_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(req.valid && !w_clr), .o_ready(w_fready),
        .i_req_type(req.req_type), .i_item_key(req.item_key),
        .i_count_change(req.count_change), .i_predicted_score(req.predicted_score),
        .i_thresh(r_thresh), .i_seeds(r_seeds),
        .o_push(w_push), .i_full(w_full), .o_data(w_qin)
    );

    lcms_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_qin), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_qout)
    );

    lcms_back #(.ROWS(ROWS), .COL_BITS(COL_BITS), .HEAVY_ENTRIES(HEAVY_ENTRIES),
                .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_data(w_qout), .o_pop(w_pop),
        .o_valid(res.valid), .i_ready(res.ready),
        .o_est(res.freq_estimate), .o_stat(res.status_code), .o_clearing(w_clr)
    );
endmodule

// File: verif/learned_count_min_sketch_unit_test.sv
// testbench for the learned count-min sketch unit with a built-in frequency predictor
`timescale 1ns / 100ps

module learned_count_min_sketch_unit_test;

    localparam int NROWS       = 4;
    localparam int NCOLS       = 1024;
    localparam int NHEAVY      = 64;
    localparam int IDLE_LIMIT  = 20000;
    localparam int POOL_SIZE   = 24;
    localparam logic [lcms_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = lcms_pkg::CFG_SEED3 + 3'd1;
    localparam logic [lcms_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [lcms_pkg::EST_W-1:0] freq_estimate;
        logic [lcms_pkg::STAT_W-1:0]       status_code;
    } freq_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lcms_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [lcms_pkg::SEED_W-1:0] i_cfg_data = '0;

    lcms_req_if req_ch ();
    lcms_res_if res_ch ();

    // predictor state
    logic [lcms_pkg::PRED_W-1:0]        pred_thresh;
    logic [lcms_pkg::SEED_W-1:0]        row_seed [NROWS];
    logic signed [lcms_pkg::EST_W-1:0]  sketch_cnt [NROWS][NCOLS];
    logic [lcms_pkg::KEY_W-1:0]         heavy_key [NHEAVY];
    logic signed [lcms_pkg::EST_W-1:0]  heavy_cnt [NHEAVY];
    int                                 heavy_used;

    freq_result_t pending_results[$];
    logic [lcms_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;

    learned_count_min_sketch_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch.sink),
        .res       (res_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // column picked by multiply-shift hashing
    function automatic logic [9:0] hash_col(input logic [lcms_pkg::KEY_W-1:0] key,
                                            input int row);
        logic [63:0] prod;
        prod = row_seed[row] * key;
        return prod[63:54];
    endfunction

    // apply one request to the predictor and return its result
    function automatic freq_result_t predict_freq(input logic rt,
                                                  input logic [lcms_pkg::KEY_W-1:0] key,
                                                  input logic signed [lcms_pkg::CHG_W-1:0] chg,
                                                  input logic [lcms_pkg::PRED_W-1:0] pred);
        freq_result_t r;
        int slot;
        logic [9:0] col;
        logic signed [lcms_pkg::EST_W-1:0] best;
        r.freq_estimate = '0;
        r.status_code = lcms_pkg::ST_OK;
        best = '0;
        slot = -1;
        for (int i = 0; i < heavy_used; i++)
            if (slot < 0 && heavy_key[i] == key) slot = i;
        if (pred > pred_thresh) begin
            if (rt == lcms_pkg::REQ_UPDATE) begin
                if (slot >= 0) begin
                    heavy_cnt[slot] = heavy_cnt[slot] + chg;
                end else if (heavy_used < NHEAVY) begin
                    heavy_key[heavy_used] = key;
                    heavy_cnt[heavy_used] = chg;
                    heavy_used++;
                end else begin
                    r.status_code = lcms_pkg::ST_FULL;
                end
            end else if (slot >= 0) begin
                r.freq_estimate = heavy_cnt[slot];
            end else begin
                r.status_code = lcms_pkg::ST_NOTFOUND;
            end
        end else begin
            // signed minimum over the rows
            for (int row = 0; row < NROWS; row++) begin
                col = hash_col(key, row);
                if (rt == lcms_pkg::REQ_UPDATE)
                    sketch_cnt[row][col] = sketch_cnt[row][col] + chg;
                else if (row == 0 || sketch_cnt[row][col] < best)
                    best = sketch_cnt[row][col];
            end
            if (rt == lcms_pkg::REQ_ESTIMATE) r.freq_estimate = best;
        end
        return r;
    endfunction

    // send one request after a random gap
    task automatic send_req(input logic rt, input logic [lcms_pkg::KEY_W-1:0] key,
                            input logic signed [lcms_pkg::CHG_W-1:0] chg,
                            input logic [lcms_pkg::PRED_W-1:0] pred);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.item_key <= key;
        req_ch.count_change <= chg;
        req_ch.predicted_score <= pred;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), predict_freq(rt, key, chg, pred));
    endtask

    // wait until every result is back and the unit is quiet
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [lcms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcms_pkg::SEED_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lcms_pkg::CFG_THRESH)
            pred_thresh = data[lcms_pkg::PRED_W-1:0];
        else if (idx inside {[lcms_pkg::CFG_SEED0:lcms_pkg::CFG_SEED3]})
            row_seed[2'(idx - lcms_pkg::CFG_SEED0)] = data | 64'd1;
    endtask

    function automatic logic [lcms_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // random request, heavy keys stay in the pool so the table fills slowly
    task automatic send_random();
        logic rt;
        logic [lcms_pkg::PRED_W-1:0] pred;
        logic [lcms_pkg::KEY_W-1:0] key;
        rt = 1'($urandom_range(0, 1));
        pred = lcms_pkg::PRED_W'($urandom);
        if (pred > pred_thresh || $urandom_range(0, 4) != 0)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            key = rand_key();
        send_req(rt, key, $urandom, pred);
    endtask

    task automatic test_directed();
        logic [lcms_pkg::KEY_W-1:0] k;
        k = key_pool[0];
        send_req(lcms_pkg::REQ_UPDATE, '0, 32'sh7fffffff, '0);
        send_req(lcms_pkg::REQ_ESTIMATE, '0, '0, '0);
        send_req(lcms_pkg::REQ_UPDATE, '1, 32'sh80000000, 16'd32768);
        send_req(lcms_pkg::REQ_ESTIMATE, '1, 32'sh7fffffff, 16'd32768);
        // counter wraps past the positive maximum
        send_req(lcms_pkg::REQ_UPDATE, k, 32'sh7fffffff, 16'd100);
        send_req(lcms_pkg::REQ_UPDATE, k, 32'sh7fffffff, 16'd100);
        send_req(lcms_pkg::REQ_ESTIMATE, k, '0, 16'd100);
        // just above the threshold goes to the exact table
        send_req(lcms_pkg::REQ_UPDATE, k, -32'sd1, 16'd32769);
        send_req(lcms_pkg::REQ_UPDATE, k, 32'sh80000000, 16'hffff);
        send_req(lcms_pkg::REQ_ESTIMATE, k, '1, 16'hffff);
        // heavy key never seen
        send_req(lcms_pkg::REQ_ESTIMATE, key_pool[1], '0, 16'hffff);
        send_req(lcms_pkg::REQ_ESTIMATE, '0, '0, 16'hffff);
        send_req(lcms_pkg::REQ_ESTIMATE, k, '0, 16'd32768);
        drain();
    endtask

    task automatic test_config();
        cfg_write(lcms_pkg::CFG_THRESH, 64'hffff_ffff_0001_0000);
        cfg_write(lcms_pkg::CFG_SEED0, '0);
        cfg_write(lcms_pkg::CFG_SEED0 + 3'd1, '1);
        cfg_write(lcms_pkg::CFG_SEED0 + 3'd2, 64'h8000_0000_0000_0000);
        cfg_write(lcms_pkg::CFG_SEED3, rand_key());
        // writes to unused indexes are dropped
        cfg_write(CFG_UNUSED_LO, '1);
        cfg_write(CFG_UNUSED_HI, 64'd5);
        for (int i = 0; i < 30; i++) send_random();
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: cfg_write(lcms_pkg::CFG_THRESH, 64'd65535);
                1: cfg_write(lcms_pkg::CFG_THRESH, 64'($urandom_range(0, 65535)));
                2: cfg_write(lcms_pkg::CFG_THRESH, 64'd32768);
                default: cfg_write(lcms_pkg::CFG_THRESH, 64'($urandom_range(30000, 50000)));
            endcase
            for (int r = 0; r < NROWS; r++)
                cfg_write(3'(lcms_pkg::CFG_SEED0 + r), rand_key());
            no_idle = (phase == 2);
            for (int i = 0; i < 300; i++) send_random();
            no_idle = 1'b0;
            drain();
        end
    endtask

    task automatic test_heavy_full();
        cfg_write(lcms_pkg::CFG_THRESH, '0);
        while (heavy_used < NHEAVY)
            send_req(lcms_pkg::REQ_UPDATE, rand_key(), $urandom,
                     lcms_pkg::PRED_W'($urandom_range(1, 65535)));
        for (int i = 0; i < 250; i++) begin
            if ($urandom_range(0, 1) != 0)
                send_req(1'($urandom_range(0, 1)), rand_key(), $urandom,
                         lcms_pkg::PRED_W'($urandom_range(1, 65535)));
            else
                send_req(1'($urandom_range(0, 1)), heavy_key[$urandom_range(0, NHEAVY - 1)],
                         $urandom, lcms_pkg::PRED_W'($urandom_range(1, 65535)));
        end
        drain();
        cfg_write(lcms_pkg::CFG_THRESH, 64'($urandom_range(0, 65535)));
        for (int i = 0; i < 200; i++) send_random();
        drain();
    endtask

    // result stall generator
    initial begin
        int n;
        res_ch.ready <= 1'b0;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        freq_result_t exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_ch.freq_estimate !== exp_r.freq_estimate) begin
                    $error("freq_estimate expected %0d actual %0d",
                           exp_r.freq_estimate, res_ch.freq_estimate);
                    error_count++;
                end
                if (res_ch.status_code !== exp_r.status_code) begin
                    $error("status_code expected %0d actual %0d",
                           exp_r.status_code, res_ch.status_code);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.req_type <= lcms_pkg::REQ_UPDATE;
        req_ch.item_key <= '0;
        req_ch.count_change <= '0;
        req_ch.predicted_score <= '0;
        pred_thresh = lcms_pkg::THRESH_RST;
        for (int r = 0; r < NROWS; r++) row_seed[r] = 64'(2 * r + 1);
        for (int r = 0; r < NROWS; r++)
            for (int c = 0; c < NCOLS; c++) sketch_cnt[r][c] = '0;
        heavy_used = 0;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config();
        test_random_settings();
        test_heavy_full();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
